// File: rtl/sbc_pkg.sv
// Shared types, command codes and constants for the sprite box collision table.
`timescale 1ns / 1ps

package sbc_pkg;

    // Default table depth and register reset value
    localparam int TARGET_SLOTS_DEF = 8;
    localparam logic [7:0] BOX_SIZE_RST = 8'd8;
    localparam logic [7:0] KILL_MAX = 8'd255;

    // Payload widths
    localparam int CMD_W = 2;
    localparam int SLOT_W = 3;
    localparam int POS_W = 8;
    localparam int CNT_W = 8;
    localparam int VEC_W = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // Item command codes (code 3 is unused and reports like a load)
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_PROJ   = 2'd1,
        CMD_PLAYER = 2'd2
    } cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;
        logic load_wr;
        logic clr_frame;
        logic scan_start;
        logic scan_step;
        logic kill;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        cmd_t cmd;
        logic live;
        logic new_frame;
        logic match;
        logic last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/sbc_ctrl.sv
// Controller state machine: sequences decode, slot scan and result hand-off.
`timescale 1ns / 1ps

module sbc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sbc_pkg::dp_stat_t    stat,
    output sbc_pkg::ctrl_cmd_t   ctl
);

    sbc_pkg::state_t state_reg;
    sbc_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        ctl = '0;
        in_ready = 1'b0;
        case (state_reg)
            sbc_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctl.latch = 1'b1;
                    state_next = sbc_pkg::ST_DECODE;
                end
            end
            sbc_pkg::ST_DECODE: begin
                case (stat.cmd)
                    sbc_pkg::CMD_LOAD: begin
                        ctl.load_wr = 1'b1;
                        state_next = sbc_pkg::ST_FINISH;
                    end
                    sbc_pkg::CMD_PROJ: begin
                        ctl.clr_frame = stat.new_frame;
                        if (stat.live) begin
                            ctl.scan_start = 1'b1;
                            state_next = sbc_pkg::ST_SCAN;
                        end else begin
                            state_next = sbc_pkg::ST_FINISH;
                        end
                    end
                    sbc_pkg::CMD_PLAYER: begin
                        ctl.scan_start = 1'b1;
                        state_next = sbc_pkg::ST_SCAN;
                    end
                    default: begin
                        state_next = sbc_pkg::ST_FINISH;
                    end
                endcase
            end
            sbc_pkg::ST_SCAN: begin
                ctl.scan_step = 1'b1;
                if (stat.match) begin
                    // only a projectile kills; a player test just reports
                    ctl.kill = (stat.cmd == sbc_pkg::CMD_PROJ);
                    state_next = sbc_pkg::ST_FINISH;
                end else if (stat.last) begin
                    state_next = sbc_pkg::ST_FINISH;
                end
            end
            sbc_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next = sbc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbc_pkg::ST_IDLE;
            end
        endcase
    end

    // A result is never loaded over one still waiting
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> stat.out_free)
        else $error("result loaded while output register busy");

endmodule

// File: rtl/sbc_dp.sv
// Datapath: target table, alive bits, frame kill tally, overlap test and result register.
`timescale 1ns / 1ps

module sbc_dp #(
    parameter int TARGET_SLOTS = sbc_pkg::TARGET_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [7:0]                      cfg_wr_data,
    input  logic [sbc_pkg::CMD_W-1:0]       in_cmd,
    input  logic [sbc_pkg::SLOT_W-1:0]      in_slot,
    input  logic [sbc_pkg::POS_W-1:0]       in_pos_x,
    input  logic [sbc_pkg::POS_W-1:0]       in_pos_y,
    input  logic                            in_live,
    input  logic                            in_new_frame,
    input  sbc_pkg::ctrl_cmd_t              ctl,
    output sbc_pkg::dp_stat_t               stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sbc_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int IDX_W = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
    localparam int EXT_W = (TARGET_SLOTS > sbc_pkg::VEC_W) ? TARGET_SLOTS : sbc_pkg::VEC_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TARGET_SLOTS - 1);

    // Latched item
    sbc_pkg::cmd_t               cmd_reg;
    logic [sbc_pkg::SLOT_W-1:0]  slot_reg;
    logic [sbc_pkg::POS_W-1:0]   px_reg;
    logic [sbc_pkg::POS_W-1:0]   py_reg;
    logic                        live_reg;
    logic                        nf_reg;

    // Table and frame state
    logic [2*sbc_pkg::POS_W-1:0] pos_mem [TARGET_SLOTS];
    logic [2*sbc_pkg::POS_W-1:0] rd_data_reg;
    logic [TARGET_SLOTS-1:0]     alive_reg;
    logic [sbc_pkg::CNT_W-1:0]   kills_reg;
    logic [sbc_pkg::VEC_W-1:0]   mask_reg;
    logic [7:0]                  box_size_reg;

    // Scan state
    logic [IDX_W-1:0]            scan_idx_reg;
    logic                        found_reg;
    logic [IDX_W-1:0]            found_idx_reg;

    // Result register
    logic                        out_valid_reg;
    logic [sbc_pkg::M_DATA_W-1:0] out_data_reg;

    logic [IDX_W-1:0]            wr_idx;
    logic                        slot_ok;
    logic [IDX_W-1:0]            rd_addr;
    logic                        rd_en;
    logic                        last;
    logic [sbc_pkg::POS_W-1:0]   tx;
    logic [sbc_pkg::POS_W-1:0]   ty;
    logic [sbc_pkg::POS_W-1:0]   dx;
    logic [sbc_pkg::POS_W-1:0]   dy;
    logic                        match;
    logic [EXT_W-1:0]            alive_ext;
    logic [EXT_W-1:0]            kill_ext;
    logic                        hit;
    logic [sbc_pkg::SLOT_W-1:0]  hit_slot;
    logic                        left;
    logic [sbc_pkg::M_DATA_W-1:0] out_data_next;

    // Box size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_size_reg <= sbc_pkg::BOX_SIZE_RST;
        end else if (cfg_wr_en) begin
            box_size_reg <= cfg_wr_data;
        end
    end

    // Item latch
    always_ff @(posedge aclk) begin
        if (ctl.latch) begin
            cmd_reg  <= sbc_pkg::cmd_t'(in_cmd);
            slot_reg <= in_slot;
            px_reg   <= in_pos_x;
            py_reg   <= in_pos_y;
            live_reg <= in_live;
            nf_reg   <= in_new_frame;
        end
    end

    // Load address; slots past the table are dropped
    assign wr_idx  = IDX_W'(slot_reg);
    assign slot_ok = 32'(slot_reg) < TARGET_SLOTS;

    // Scan sequencing: read of the next slot overlaps the compare of this one
    assign last    = (scan_idx_reg == LAST_IDX);
    assign rd_en   = ctl.scan_start | ctl.scan_step;
    assign rd_addr = (ctl.scan_start || last) ? '0 : scan_idx_reg + IDX_W'(1);

    // Position table
    always_ff @(posedge aclk) begin
        if (ctl.load_wr && slot_ok) begin
            pos_mem[wr_idx] <= {py_reg, px_reg};
        end
        if (rd_en) begin
            rd_data_reg <= pos_mem[rd_addr];
        end
    end

    // Overlap test of the slot under the scan index
    assign tx    = rd_data_reg[sbc_pkg::POS_W-1:0];
    assign ty    = rd_data_reg[2*sbc_pkg::POS_W-1:sbc_pkg::POS_W];
    assign dx    = (px_reg >= tx) ? px_reg - tx : tx - px_reg;
    assign dy    = (py_reg >= ty) ? py_reg - ty : ty - py_reg;
    assign match = alive_reg[scan_idx_reg] && (dx < box_size_reg) && (dy < box_size_reg);

    // Scan index and first hit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
        end else begin
            if (ctl.latch) begin
                found_reg     <= 1'b0;
                found_idx_reg <= '0;
            end else if (ctl.scan_step && match) begin
                found_reg     <= 1'b1;
                found_idx_reg <= scan_idx_reg;
            end
            if (ctl.scan_start) begin
                scan_idx_reg <= '0;
            end else if (ctl.scan_step && !last) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
    end

    // Alive bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= '0;
        end else if (ctl.load_wr && slot_ok) begin
            alive_reg[wr_idx] <= live_reg;
        end else if (ctl.kill) begin
            alive_reg[scan_idx_reg] <= 1'b0;
        end
    end

    // Frame kill count and mask
    assign kill_ext = EXT_W'(1) << scan_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kills_reg <= '0;
            mask_reg  <= '0;
        end else if (ctl.clr_frame) begin
            kills_reg <= '0;
            mask_reg  <= '0;
        end else if (ctl.kill) begin
            if (kills_reg != sbc_pkg::KILL_MAX) begin
                kills_reg <= kills_reg + 8'd1;
            end
            mask_reg <= mask_reg | kill_ext[sbc_pkg::VEC_W-1:0];
        end
    end

    // Result fields
    assign alive_ext = EXT_W'(alive_reg);
    assign hit       = found_reg;
    assign hit_slot  = found_reg ? sbc_pkg::SLOT_W'(found_idx_reg) : '0;
    assign left      = (cmd_reg == sbc_pkg::CMD_PROJ) && live_reg && !found_reg;
    assign out_data_next = {3'b000, alive_ext[sbc_pkg::VEC_W-1:0], mask_reg, kills_reg,
                            left, hit_slot, hit};

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status back to the controller
    assign stat.cmd       = cmd_reg;
    assign stat.live      = live_reg;
    assign stat.new_frame = nf_reg;
    assign stat.match     = match;
    assign stat.last      = last;
    assign stat.out_free  = !out_valid_reg || m_tready;

    // A kill only lands on a slot that was alive, and clears it
    a_kill_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.kill |-> alive_reg[scan_idx_reg])
        else $error("kill on a dead slot");

    a_kill_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.kill |=> !alive_reg[$past(scan_idx_reg)])
        else $error("killed slot still alive");

    // No hit means slot field zero in the result
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.out_load && !found_reg) |=> (out_data_reg[3:1] == 3'b000))
        else $error("hit_slot set without a hit");

endmodule

// File: rtl/sprite_box_collision_table.sv
// Top level of the sprite box collision table: stream ports, controller and datapath.
//
//  port group  dir  item contents
//  s_*         in   command item: cmd in tuser; slot, position, live, new_frame in tdata
//  m_*         out  one result item per command item
//  cfg_*       in   box_size register write
//
// A load item and an inactive projectile need no scan; other test items wait on the
// scan, which visits one slot of the position table per cycle through its single
// read port (stops early on the first hit).
// Reset is synchronous, active low; alive bits, kill tally and box_size are
// cleared/reset, target positions are not. A result waits in the output
// register while m_tready is low; the next item is accepted meanwhile.
`timescale 1ns / 1ps

module sprite_box_collision_table #(
    parameter int TARGET_SLOTS = sbc_pkg::TARGET_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // box_size register
    input  logic                            cfg_wr_en,
    input  logic [7:0]                      cfg_wr_data,
    // command items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sbc_pkg::S_DATA_W-1:0]    s_tdata,  // slot[2:0], pos_x[10:3], pos_y[18:11],
                                                      // live[19], new_frame[20], zero[23:21]
    input  logic [sbc_pkg::CMD_W-1:0]       s_tuser,  // cmd[1:0]
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sbc_pkg::M_DATA_W-1:0]    m_tdata   // hit[0], hit_slot[3:1],
                                                      // projectile_left[4], kill_count[12:5],
                                                      // shot_mask[20:13], alive_bits[28:21],
                                                      // zero[31:29]
);

    sbc_pkg::ctrl_cmd_t ctl;
    sbc_pkg::dp_stat_t  stat;

    sbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    sbc_dp #(
        .TARGET_SLOTS (TARGET_SLOTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_cmd       (s_tuser),
        .in_slot      (s_tdata[2:0]),
        .in_pos_x     (s_tdata[10:3]),
        .in_pos_y     (s_tdata[18:11]),
        .in_live      (s_tdata[19]),
        .in_new_frame (s_tdata[20]),
        .ctl          (ctl),
        .stat         (stat),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// File: tb/sprite_box_collision_table_checker.sv
// Result checker for the sprite box collision table: shadows the table, checks result items.
`timescale 1ns / 1ps

module sprite_box_collision_table_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [7:0]                      cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sbc_pkg::S_DATA_W-1:0]    s_tdata,  // slot, pos_x, pos_y, live, new_frame
    input  logic [sbc_pkg::CMD_W-1:0]       s_tuser,  // cmd
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sbc_pkg::M_DATA_W-1:0]    m_tdata,  // hit, hit_slot, projectile_left,
                                                      // kill_count, shot_mask, alive_bits
    output int unsigned                     fail_count,
    output int unsigned                     backlog
);
    import sbc_pkg::*;

    localparam int SLOTS = TARGET_SLOTS_DEF;

    typedef struct packed {
        logic       hit;
        logic [2:0] hit_slot;
        logic       left;
        logic [7:0] kills;
        logic [7:0] mask;
        logic [7:0] alive;
    } report_t;

    // Shadow of the block's state
    logic [7:0]       box_edge;
    logic [7:0]       tgt_x [SLOTS];
    logic [7:0]       tgt_y [SLOTS];
    logic [SLOTS-1:0] tgt_alive;
    logic [7:0]       kills;
    logic [7:0]       shot_mask;

    report_t due_reports [$];

    function automatic logic [7:0] span(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Lowest alive slot whose box overlaps the given point, -1 if none
    function automatic int lowest_overlap(input logic [7:0] px, input logic [7:0] py);
        for (int j = 0; j < SLOTS; j++) begin
            if (tgt_alive[j] && span(px, tgt_x[j]) < box_edge && span(py, tgt_y[j]) < box_edge)
                return j;
        end
        return -1;
    endfunction

    // Apply one command item to the shadow table and return its report
    function automatic report_t collide_item(input logic [CMD_W-1:0] cmd,
                                             input logic [2:0] slot,
                                             input logic [7:0] px,
                                             input logic [7:0] py,
                                             input logic live,
                                             input logic new_frame);
        report_t res;
        int found;
        res = '0;
        if (cmd == CMD_LOAD) begin
            tgt_x[slot] = px;
            tgt_y[slot] = py;
            tgt_alive[slot] = live;
        end else if (cmd == CMD_PROJ) begin
            if (new_frame) begin
                kills = '0;
                shot_mask = '0;
            end
            // inactive projectile: no scan, nothing left
            if (live) begin
                found = lowest_overlap(px, py);
                if (found >= 0) begin
                    tgt_alive[found] = 1'b0;
                    if (kills != KILL_MAX)
                        kills = kills + 8'd1;
                    shot_mask[found] = 1'b1;
                    res.hit = 1'b1;
                    res.hit_slot = 3'(found);
                end else begin
                    res.left = 1'b1;
                end
            end
        end else if (cmd == CMD_PLAYER) begin
            // report only, no state change
            found = lowest_overlap(px, py);
            if (found >= 0) begin
                res.hit = 1'b1;
                res.hit_slot = 3'(found);
            end
        end
        res.kills = kills;
        res.mask = shot_mask;
        res.alive = tgt_alive;
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Watch both channels and the register port
    always @(posedge aclk) begin
        report_t want;
        report_t got;
        if (!aresetn) begin
            box_edge = BOX_SIZE_RST;
            tgt_alive = '0;
            kills = '0;
            shot_mask = '0;
            due_reports.delete();
            backlog <= 0;
        end else begin
            if (cfg_wr_en)
                box_edge = cfg_wr_data;
            if (s_tvalid && s_tready)
                due_reports.push_back(collide_item(s_tuser, s_tdata[2:0], s_tdata[10:3],
                                                   s_tdata[18:11], s_tdata[19], s_tdata[20]));
            if (m_tvalid && m_tready) begin
                got.hit = m_tdata[0];
                got.hit_slot = m_tdata[3:1];
                got.left = m_tdata[4];
                got.kills = m_tdata[12:5];
                got.mask = m_tdata[20:13];
                got.alive = m_tdata[28:21];
                if (due_reports.size() == 0) begin
                    $error("result item with no command item outstanding");
                    fail_count++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("hit", want.hit, got.hit);
                    check_field("hit_slot", want.hit_slot, got.hit_slot);
                    check_field("projectile_left", want.left, got.left);
                    check_field("kill_count", want.kills, got.kills);
                    check_field("shot_mask", want.mask, got.mask);
                    check_field("alive_bits", want.alive, got.alive);
                end
            end
            backlog <= due_reports.size();
        end
    end

endmodule

// File: tb/sprite_box_collision_table_test.sv
// Stimulus top for the sprite box collision table: drives command items and register writes.
`timescale 1ns / 1ps

module sprite_box_collision_table_test;
    import sbc_pkg::*;

    // Spare command code: changes nothing, reports like a load
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [7:0]             cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;

    int unsigned fail_count;
    int unsigned backlog;
    int unsigned src_gap_max = 0;
    int unsigned sink_gap_max = 0;

    sprite_box_collision_table dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    sprite_box_collision_table_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    // 50 MHz clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("sprite_box_collision_table_test: done, errors");
        $finish;
    end

    // Result side: random stall after each accepted item
    initial begin
        int unsigned wait_left;
        wait_left = 0;
        do @(posedge aclk); while (!aresetn);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                wait_left = $urandom_range(sink_gap_max, 0);
                if (wait_left != 0)
                    m_tready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                if (wait_left == 0)
                    m_tready <= 1'b1;
            end
        end
    end

    // Offer one command item and hold it until accepted
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [2:0] slot,
                            input logic [7:0] px, input logic [7:0] py,
                            input logic live, input logic new_frame);
        int unsigned gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {3'b000, new_frame, live, py, px, slot};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drain all outstanding results, then allow for the longest scan
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (backlog != 0);
        repeat (TARGET_SLOTS_DEF + 8) @(posedge aclk);
    endtask

    task automatic write_box_size(input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Coordinate within spread of a centre, wrapping at the byte boundary
    function automatic logic [7:0] near(input logic [7:0] centre, input int unsigned spread);
        return centre + 8'($urandom_range(2 * spread, 0)) - 8'(spread);
    endfunction

    // Random traffic clustered round a moving centre so that boxes do collide
    task automatic run_scene(input int count, input int unsigned spread);
        logic [7:0] cx;
        logic [7:0] cy;
        int unsigned pick;
        cx = 8'($urandom_range(255, 0));
        cy = 8'($urandom_range(255, 0));
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 39) begin
                cx = 8'($urandom_range(255, 0));
                cy = 8'($urandom_range(255, 0));
            end
            pick = $urandom_range(99, 0);
            if (pick < 35)
                send_cmd(CMD_LOAD, 3'($urandom_range(7, 0)), near(cx, spread), near(cy, spread),
                         $urandom_range(9, 0) != 0, 1'($urandom_range(1, 0)));
            else if (pick < 72)
                send_cmd(CMD_PROJ, 3'($urandom_range(7, 0)), near(cx, spread), near(cy, spread),
                         $urandom_range(7, 0) != 0, $urandom_range(11, 0) == 0);
            else if (pick < 90)
                send_cmd(CMD_PLAYER, 3'($urandom_range(7, 0)), near(cx, spread),
                         near(cy, spread), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            else if (pick < 93)
                send_cmd(CMD_SPARE, 3'($urandom_range(7, 0)), 8'($urandom_range(255, 0)),
                         8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
                         1'($urandom_range(1, 0)));
            else
                send_cmd(CMD_W'($urandom_range(2, 0)), 3'($urandom_range(7, 0)),
                         8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                         1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
        end
    endtask

    // Revive and shoot one target after another, enough kills to saturate the count
    task automatic run_kill_streak(input int kills);
        send_cmd(CMD_PROJ, 3'd0, 8'd0, 8'd0, 1'b0, 1'b1);
        for (int k = 0; k < kills; k++) begin
            send_cmd(CMD_LOAD, 3'(k % 8), 8'($urandom_range(250, 5)), 8'($urandom_range(250, 5)),
                     1'b1, 1'($urandom_range(1, 0)));
            send_cmd(CMD_PROJ, 3'($urandom_range(7, 0)), 8'($urandom_range(255, 0)),
                     8'($urandom_range(255, 0)), 1'b1, 1'b0);
        end
    endtask

    // Main sequence
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items at the reset box size of 8
        src_gap_max = 6;
        sink_gap_max = 6;
        send_cmd(CMD_PLAYER, 3'd0, 8'd0, 8'd0, 1'b1, 1'b0);        // empty table
        send_cmd(CMD_PROJ, 3'd7, 8'd255, 8'd255, 1'b0, 1'b1);      // inactive, new frame
        send_cmd(CMD_LOAD, 3'd0, 8'd0, 8'd0, 1'b1, 1'b0);
        send_cmd(CMD_LOAD, 3'd7, 8'd255, 8'd255, 1'b1, 1'b0);
        send_cmd(CMD_LOAD, 3'd3, 8'd100, 8'd100, 1'b0, 1'b0);      // dead target
        send_cmd(CMD_PLAYER, 3'd0, 8'd7, 8'd7, 1'b1, 1'b0);        // just inside
        send_cmd(CMD_PLAYER, 3'd0, 8'd8, 8'd0, 1'b1, 1'b0);        // on the edge: miss
        send_cmd(CMD_PROJ, 3'd0, 8'd248, 8'd248, 1'b1, 1'b0);      // kills slot 7
        send_cmd(CMD_PROJ, 3'd0, 8'd100, 8'd100, 1'b1, 1'b0);      // misses the dead one
        send_cmd(CMD_SPARE, 3'd5, 8'd0, 8'd0, 1'b1, 1'b1);
        send_cmd(CMD_LOAD, 3'd1, 8'd4, 8'd4, 1'b1, 1'b0);
        send_cmd(CMD_LOAD, 3'd2, 8'd2, 8'd2, 1'b1, 1'b0);
        send_cmd(CMD_PROJ, 3'd0, 8'd3, 8'd3, 1'b1, 1'b0);          // three overlap: lowest dies
        send_cmd(CMD_PROJ, 3'd0, 8'd3, 8'd3, 1'b1, 1'b0);
        send_cmd(CMD_LOAD, 3'd5, 8'd128, 8'd128, 1'b1, 1'b1);      // new_frame ignored
        send_cmd(CMD_PROJ, 3'd0, 8'd128, 8'd130, 1'b1, 1'b1);      // clears then kills
        send_cmd(CMD_PLAYER, 3'd0, 8'd2, 8'd2, 1'b0, 1'b1);        // live ignored
        send_cmd(CMD_PROJ, 3'd0, 8'd2, 8'd2, 1'b0, 1'b0);          // inactive, no clear
        send_cmd(CMD_SPARE, 3'd7, 8'd255, 8'd255, 1'b0, 1'b0);
        settle();

        // Smallest overlapping box, no idling on either side
        write_box_size(8'd1);
        src_gap_max = 0;
        sink_gap_max = 0;
        run_scene(70, 2);
        settle();

        // Largest box: long run of kills within one frame
        write_box_size(8'd255);
        src_gap_max = 2;
        sink_gap_max = 0;
        run_kill_streak(265);
        settle();

        // Zero box: nothing overlaps
        write_box_size(8'd0);
        src_gap_max = 6;
        sink_gap_max = 6;
        run_scene(50, 20);
        settle();

        write_box_size(8'($urandom_range(254, 2)));
        src_gap_max = 6;
        sink_gap_max = 0;
        run_scene(70, 40);
        settle();

        write_box_size(8'd24);
        src_gap_max = 0;
        sink_gap_max = 6;
        run_scene(70, 30);
        settle();

        write_box_size(8'd8);
        src_gap_max = 6;
        sink_gap_max = 6;
        run_scene(70, 12);
        settle();

        if (fail_count == 0)
            $display("sprite_box_collision_table_test: done, clean");
        else
            $display("sprite_box_collision_table_test: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sbc_pkg.sv
rtl/sbc_ctrl.sv
rtl/sbc_dp.sv
rtl/sprite_box_collision_table.sv
tb/sprite_box_collision_table_checker.sv
tb/sprite_box_collision_table_test.sv
